FILE: hw/rtl/ctas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctas_pkg;

    localparam int CENTILUX_W = 23;
    localparam int LUX_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int LIGHT_TH_W = 17;
    localparam int GYRO_TH_W  = 15;
    localparam int ACC_W      = 10;
    localparam int TICKS_W    = 16;

    // The lux value is (centilux / 4) / 25, done as a multiply by a reciprocal.
    // The reciprocal is exact for every 21-bit quotient input.
    localparam int               LUX_PRE_SHIFT = 2;
    localparam int               LUX_DIV_IN_W  = CENTILUX_W - LUX_PRE_SHIFT;
    localparam int               LUX_RECIP_W   = 22;
    localparam int               LUX_SHIFT     = 26;
    localparam logic [LUX_RECIP_W-1:0] LUX_RECIP = 22'd2684355;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_TH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_TH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_TH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_NOMINAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZ_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TICKS = 3'd6;

    localparam logic [LIGHT_TH_W-1:0] RST_LIGHT_TH    = 17'd300;
    localparam logic [GYRO_TH_W-1:0]  RST_GYRO_TH     = 15'd5000;
    localparam logic [ACC_W-1:0]      RST_ACC_TH      = 10'd30;
    localparam logic [ACC_W-1:0]      RST_ACC_NOMINAL = 10'd100;
    localparam logic [TICKS_W-1:0]    RST_BUZZ_TICKS  = 16'd256;
    localparam logic [TICKS_W-1:0]    RST_WAIT_TICKS  = 16'd256;
    localparam logic [TICKS_W-1:0]    RST_CYCLE_TICKS = 16'd2048;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BUZZ = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUZZ = 3'b010,
        ST_WAIT = 3'b100
    } alarm_state_t;

    typedef struct packed {
        logic [LIGHT_TH_W-1:0] lux_delta_lim;
        logic [GYRO_TH_W-1:0]  gyro_rate_lim;
        logic [ACC_W-1:0]      acc_dev_lim;
        logic [ACC_W-1:0]      acc_nominal;
        logic [TICKS_W-1:0]    buzz_ticks;
        logic [TICKS_W-1:0]    wait_ticks;
        logic [TICKS_W-1:0]    cycle_ticks;
    } cfg_t;

    typedef struct packed {
        logic light_hit;
        logic gyro_hit;
        logic acc_hit;
    } hits_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       buzzer_on;
        logic       significant;
        hits_t      hits;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/change_triggered_alarm_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Alarm sequencer driven by sensor samples and time ticks. Each transaction on
// the input channel gives exactly one result transaction, which reports the
// alarm mode after that item and, for a sample judged while idle, which of the
// light, gyro and acceleration tests fired. Items pass through an input
// register and then a result register, with a combinational judge-and-update
// step between the two, so a transaction is accepted every cycle while the
// output side is not stalled. Configuration writes take effect on the next
// edge and belong between items.

module change_triggered_alarm_sequencer #(
    parameter int TIMER_BITS = 16,
    parameter int AXIS_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [ctas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctas_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [ctas_pkg::CENTILUX_W-1:0]     light_centilux,
    input  logic                                light_valid,
    input  logic signed [AXIS_BITS-1:0]         gyro_x,
    input  logic signed [AXIS_BITS-1:0]         gyro_y,
    input  logic signed [AXIS_BITS-1:0]         gyro_z,
    input  logic signed [AXIS_BITS-1:0]         acc_x,
    input  logic signed [AXIS_BITS-1:0]         acc_y,
    input  logic signed [AXIS_BITS-1:0]         acc_z,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          mode,
    output logic                                buzzer_on,
    output logic                                significant,
    output logic                                light_hit,
    output logic                                gyro_hit,
    output logic                                acc_hit
);
    import ctas_pkg::*;

    cfg_t                        cfg;

    logic                        item_valid_reg;
    logic                        item_valid_next;
    logic                        cmd_reg;
    logic [CENTILUX_W-1:0]       light_centilux_reg;
    logic                        light_valid_reg;
    logic signed [AXIS_BITS-1:0] gyro_x_reg;
    logic signed [AXIS_BITS-1:0] gyro_y_reg;
    logic signed [AXIS_BITS-1:0] gyro_z_reg;
    logic signed [AXIS_BITS-1:0] acc_x_reg;
    logic signed [AXIS_BITS-1:0] acc_y_reg;
    logic signed [AXIS_BITS-1:0] acc_z_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    result_t                     res_reg;
    result_t                     res_next;

    logic                        advance;
    logic                        in_fire;
    logic [LUX_W-1:0]            lux;
    logic [LUX_W-1:0]            last_lux;
    hits_t                       hits;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign item_valid_next = in_fire || (item_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && !out_ready);

    ctas_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctas_judge #(
        .AXIS_BITS (AXIS_BITS)
    ) u_judge (
        .cfg            (cfg),
        .light_centilux (light_centilux_reg),
        .light_valid    (light_valid_reg),
        .gyro_x         (gyro_x_reg),
        .gyro_y         (gyro_y_reg),
        .gyro_z         (gyro_z_reg),
        .acc_x          (acc_x_reg),
        .acc_y          (acc_y_reg),
        .acc_z          (acc_z_reg),
        .last_lux       (last_lux),
        .lux            (lux),
        .hits           (hits)
    );

    ctas_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .fire     (advance),
        .cmd      (cmd_reg),
        .lux      (lux),
        .hits     (hits),
        .last_lux (last_lux),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg            <= cmd;
            light_centilux_reg <= light_centilux;
            light_valid_reg    <= light_valid;
            gyro_x_reg         <= gyro_x;
            gyro_y_reg         <= gyro_y;
            gyro_z_reg         <= gyro_z;
            acc_x_reg          <= acc_x;
            acc_y_reg          <= acc_y;
            acc_z_reg          <= acc_z;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = res_reg.mode;
    assign buzzer_on   = res_reg.buzzer_on;
    assign significant = res_reg.significant;
    assign light_hit   = res_reg.hits.light_hit;
    assign gyro_hit    = res_reg.hits.gyro_hit;
    assign acc_hit     = res_reg.hits.acc_hit;

`ifndef SYNTHESIS
    significant_in_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && significant) |-> (mode == MODE_BUZZ && buzzer_on))
        else $error("A significant result does not report the buzz mode.");

    stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid_reg && out_valid_reg && !out_ready))
        else $error("Input stalled while the pipeline had room.");

    item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("A held transaction did not move to the result register.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ctas_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ctas_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ctas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctas_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ctas_pkg::cfg_t                      cfg
);
    import ctas_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LIGHT_TH:    cfg_next.lux_delta_lim = cfg_data[LIGHT_TH_W-1:0];
                REG_GYRO_TH:     cfg_next.gyro_rate_lim = cfg_data[GYRO_TH_W-1:0];
                REG_ACC_TH:      cfg_next.acc_dev_lim   = cfg_data[ACC_W-1:0];
                REG_ACC_NOMINAL: cfg_next.acc_nominal   = cfg_data[ACC_W-1:0];
                REG_BUZZ_TICKS:  cfg_next.buzz_ticks    = cfg_data[TICKS_W-1:0];
                REG_WAIT_TICKS:  cfg_next.wait_ticks    = cfg_data[TICKS_W-1:0];
                REG_CYCLE_TICKS: cfg_next.cycle_ticks   = cfg_data[TICKS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lux_delta_lim <= RST_LIGHT_TH;
            cfg_reg.gyro_rate_lim <= RST_GYRO_TH;
            cfg_reg.acc_dev_lim   <= RST_ACC_TH;
            cfg_reg.acc_nominal   <= RST_ACC_NOMINAL;
            cfg_reg.buzz_ticks    <= RST_BUZZ_TICKS;
            cfg_reg.wait_ticks    <= RST_WAIT_TICKS;
            cfg_reg.cycle_ticks   <= RST_CYCLE_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ctas_judge.sv
`timescale 1ns / 1ps
`default_nettype none

module ctas_judge #(
    parameter int AXIS_BITS = 16
) (
    input  ctas_pkg::cfg_t                      cfg,
    input  logic [ctas_pkg::CENTILUX_W-1:0]     light_centilux,
    input  logic                                light_valid,
    input  logic signed [AXIS_BITS-1:0]         gyro_x,
    input  logic signed [AXIS_BITS-1:0]         gyro_y,
    input  logic signed [AXIS_BITS-1:0]         gyro_z,
    input  logic signed [AXIS_BITS-1:0]         acc_x,
    input  logic signed [AXIS_BITS-1:0]         acc_y,
    input  logic signed [AXIS_BITS-1:0]         acc_z,
    input  logic [ctas_pkg::LUX_W-1:0]          last_lux,
    output logic [ctas_pkg::LUX_W-1:0]          lux,
    output ctas_pkg::hits_t                     hits
);
    import ctas_pkg::*;

    localparam int SQ_W    = 2 * AXIS_BITS;
    localparam int SUM_W   = SQ_W + 2;
    localparam int HI_W    = ACC_W + 1;
    localparam int HI_SQ_W = 2 * HI_W;
    localparam int LO_SQ_W = 2 * ACC_W;
    localparam int CMP_W   = (SUM_W > HI_SQ_W) ? SUM_W : HI_SQ_W;
    localparam int GW      = (AXIS_BITS > GYRO_TH_W) ? AXIS_BITS : GYRO_TH_W;
    localparam int PROD_W  = LUX_DIV_IN_W + LUX_RECIP_W;

    function automatic logic [AXIS_BITS-1:0] magnitude(input logic [AXIS_BITS-1:0] v);
        logic [AXIS_BITS-1:0] neg;
        neg = ~v + {{(AXIS_BITS-1){1'b0}}, 1'b1};
        return v[AXIS_BITS-1] ? neg : v;
    endfunction

    logic [LUX_DIV_IN_W-1:0] lux_div_in;
    logic [PROD_W-1:0]       lux_prod;
    logic [LUX_W-1:0]        lux_raw;
    logic [LUX_W-1:0]        lux_diff;

    logic [AXIS_BITS-1:0]    gmag_x;
    logic [AXIS_BITS-1:0]    gmag_y;
    logic [AXIS_BITS-1:0]    gmag_z;

    logic [AXIS_BITS-1:0]    amag_x;
    logic [AXIS_BITS-1:0]    amag_y;
    logic [AXIS_BITS-1:0]    amag_z;
    logic [SQ_W-1:0]         sq_x;
    logic [SQ_W-1:0]         sq_y;
    logic [SQ_W-1:0]         sq_z;
    logic [SUM_W-1:0]        sq_sum;

    logic [HI_W-1:0]         acc_hi;
    logic [HI_SQ_W-1:0]      acc_hi_sq;
    logic                    acc_lo_en;
    logic [ACC_W-1:0]        acc_lo;
    logic [LO_SQ_W-1:0]      acc_lo_sq;

    // Light: lux is centilux / 100, zero when the reading is not valid.
    assign lux_div_in = light_centilux[CENTILUX_W-1:LUX_PRE_SHIFT];
    assign lux_prod   = PROD_W'(lux_div_in) * PROD_W'(LUX_RECIP);
    assign lux_raw    = lux_prod[LUX_SHIFT +: LUX_W];
    assign lux        = light_valid ? lux_raw : '0;
    assign lux_diff   = (lux > last_lux) ? (lux - last_lux) : (last_lux - lux);

    // Gyro: any axis magnitude above the threshold.
    assign gmag_x = magnitude(gyro_x);
    assign gmag_y = magnitude(gyro_y);
    assign gmag_z = magnitude(gyro_z);

    // Acceleration: floor(sqrt(S)) > nominal + threshold exactly when
    // S >= (nominal + threshold + 1)^2, and floor(sqrt(S)) < nominal - threshold
    // exactly when S < (nominal - threshold)^2, so no root is needed.
    assign amag_x = magnitude(acc_x);
    assign amag_y = magnitude(acc_y);
    assign amag_z = magnitude(acc_z);
    assign sq_x   = SQ_W'(amag_x) * SQ_W'(amag_x);
    assign sq_y   = SQ_W'(amag_y) * SQ_W'(amag_y);
    assign sq_z   = SQ_W'(amag_z) * SQ_W'(amag_z);
    assign sq_sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

    assign acc_hi    = HI_W'(cfg.acc_nominal) + HI_W'(cfg.acc_dev_lim) + HI_W'(1);
    assign acc_hi_sq = HI_SQ_W'(acc_hi) * HI_SQ_W'(acc_hi);
    assign acc_lo_en = cfg.acc_nominal > cfg.acc_dev_lim;
    assign acc_lo    = cfg.acc_nominal - cfg.acc_dev_lim;
    assign acc_lo_sq = LO_SQ_W'(acc_lo) * LO_SQ_W'(acc_lo);

    always_comb
    begin
        hits.light_hit = lux_diff > cfg.lux_delta_lim;
        hits.gyro_hit  = (GW'(gmag_x) > GW'(cfg.gyro_rate_lim))
                      || (GW'(gmag_y) > GW'(cfg.gyro_rate_lim))
                      || (GW'(gmag_z) > GW'(cfg.gyro_rate_lim));
        hits.acc_hit   = (CMP_W'(sq_sum) >= CMP_W'(acc_hi_sq))
                      || (acc_lo_en && (CMP_W'(sq_sum) < CMP_W'(acc_lo_sq)));
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ctas_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ctas_seq #(
    parameter int TIMER_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctas_pkg::cfg_t               cfg,
    input  logic                         fire,
    input  logic                         cmd,
    input  logic [ctas_pkg::LUX_W-1:0]   lux,
    input  ctas_pkg::hits_t              hits,
    output logic [ctas_pkg::LUX_W-1:0]   last_lux,
    output ctas_pkg::result_t            res
);
    import ctas_pkg::*;

    alarm_state_t            state_reg;
    alarm_state_t            state_next;
    logic [TIMER_BITS-1:0]   phase_left_reg;
    logic [TIMER_BITS-1:0]   phase_left_next;
    logic [TIMER_BITS-1:0]   cycle_left_reg;
    logic [TIMER_BITS-1:0]   cycle_left_next;
    logic [LUX_W-1:0]        last_lux_reg;
    logic [LUX_W-1:0]        last_lux_next;
    logic [TIMER_BITS-1:0]   phase_dec;
    logic [TIMER_BITS-1:0]   cycle_dec;
    logic                    judged;
    logic                    any_hit;

    assign any_hit   = hits.light_hit || hits.gyro_hit || hits.acc_hit;
    assign phase_dec = (phase_left_reg != '0) ? (phase_left_reg - TIMER_BITS'(1)) : '0;
    assign cycle_dec = (cycle_left_reg != '0) ? (cycle_left_reg - TIMER_BITS'(1)) : '0;

    always_comb
    begin
        state_next      = state_reg;
        phase_left_next = phase_left_reg;
        cycle_left_next = cycle_left_reg;
        last_lux_next   = last_lux_reg;
        judged          = 1'b0;
        if (cmd == CMD_SAMPLE)
        begin
            if (state_reg == ST_IDLE)
            begin
                judged        = 1'b1;
                last_lux_next = lux;
                if (any_hit)
                begin
                    state_next      = ST_BUZZ;
                    phase_left_next = TIMER_BITS'(cfg.buzz_ticks);
                    cycle_left_next = TIMER_BITS'(cfg.cycle_ticks);
                end
            end
        end
        else if (state_reg != ST_IDLE)
        begin
            cycle_left_next = cycle_dec;
            phase_left_next = phase_dec;
            // The end of the cycle wins over a phase change, in either phase.
            if (cycle_dec == '0)
            begin
                state_next      = ST_IDLE;
                phase_left_next = '0;
            end
            else if (phase_dec == '0)
            begin
                case (state_reg)
                    ST_BUZZ:
                    begin
                        state_next      = ST_WAIT;
                        phase_left_next = TIMER_BITS'(cfg.wait_ticks);
                    end
                    ST_WAIT:
                    begin
                        state_next      = ST_BUZZ;
                        phase_left_next = TIMER_BITS'(cfg.buzz_ticks);
                    end
                    default:
                    begin
                        state_next      = ST_IDLE;
                        phase_left_next = '0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        case (state_next)
            ST_BUZZ: res.mode = MODE_BUZZ;
            ST_WAIT: res.mode = MODE_WAIT;
            default: res.mode = MODE_IDLE;
        endcase
        res.buzzer_on   = state_next == ST_BUZZ;
        res.significant = judged && any_hit;
        res.hits        = judged ? hits : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_left_reg <= '0;
            cycle_left_reg <= '0;
            last_lux_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            phase_left_reg <= phase_left_next;
            cycle_left_reg <= cycle_left_next;
            last_lux_reg   <= last_lux_next;
        end
    end

    assign last_lux = last_lux_reg;

`ifndef SYNTHESIS
    idle_timers_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (phase_left_reg == '0 && cycle_left_reg == '0))
        else $error("Timers are not clear while the alarm is idle.");

    trigger_starts_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd == CMD_SAMPLE && state_reg == ST_IDLE && any_hit)
        |=> (state_reg == ST_BUZZ))
        else $error("A significant sample did not start a buzz phase.");

    tick_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd == CMD_TICK && state_reg != ST_IDLE && cycle_left_reg != '0)
        |=> (cycle_left_reg == $past(cycle_left_reg) - TIMER_BITS'(1)))
        else $error("A tick did not count the cycle timer down by one.");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ctas_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_LUX = 83886;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic                  cmd;
        logic [CENTILUX_W-1:0] centilux;
        logic                  lvalid;
        logic signed [15:0]    gyro [3];
        logic signed [15:0]    acc [3];
    } sample_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        sample_t               item;
        bit                    has_exp;
        result_t               exp_res;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [CENTILUX_W-1:0]  light_centilux;
    logic                   light_valid;
    logic signed [15:0]     gyro_x, gyro_y, gyro_z;
    logic signed [15:0]     acc_x, acc_y, acc_z;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             mode;
    logic                   buzzer_on;
    logic                   significant;
    logic                   light_hit;
    logic                   gyro_hit;
    logic                   acc_hit;

    change_triggered_alarm_sequencer dut (.*);

    cfg_t        model_cfg;
    logic [1:0]  model_mode;
    logic [15:0] model_phase;
    logic [15:0] model_cycle;
    logic [16:0] model_last_lux;

    result_t pending_results [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      alarm_triggers = 0;
    int      buzz_expiries = 0;
    int      settings_used = 1;
    int      quiet_cycles = 0;
    bit      src_gaps = 1'b0;
    bit      sink_stalls = 1'b0;
    bit      hold_req = 1'b0;

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    function automatic longint abs_diff(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic longint axis_mag(input logic signed [15:0] v);
        return (v < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic signed [15:0] clamp_axis(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic int rand_sign();
        return ($urandom_range(0, 1) != 0) ? -1 : 1;
    endfunction

    function automatic result_t predict_alarm_result(input sample_t s);
        result_t r;
        logic [16:0] lux;
        longint gth;
        longint sum;
        longint root;
        longint cand;
        r = '0;
        if (s.cmd == CMD_SAMPLE)
        begin
            if (model_mode == MODE_IDLE)
            begin
                lux = s.lvalid ? 17'(s.centilux / 100) : '0;
                r.hits.light_hit = abs_diff(lux, model_last_lux)
                                   > longint'(model_cfg.lux_delta_lim);
                model_last_lux = lux;
                gth = longint'(model_cfg.gyro_rate_lim);
                r.hits.gyro_hit = axis_mag(s.gyro[0]) > gth || axis_mag(s.gyro[1]) > gth
                                  || axis_mag(s.gyro[2]) > gth;
                sum = axis_mag(s.acc[0]) * axis_mag(s.acc[0])
                      + axis_mag(s.acc[1]) * axis_mag(s.acc[1])
                      + axis_mag(s.acc[2]) * axis_mag(s.acc[2]);
                root = 0;
                for (int b = 17; b >= 0; b--)
                begin
                    cand = root | (longint'(1) << b);
                    if (cand * cand <= sum)
                        root = cand;
                end
                r.hits.acc_hit = abs_diff(root, longint'(model_cfg.acc_nominal))
                                 > longint'(model_cfg.acc_dev_lim);
                r.significant = r.hits.light_hit || r.hits.gyro_hit || r.hits.acc_hit;
                if (r.significant)
                begin
                    alarm_triggers++;
                    model_mode = MODE_BUZZ;
                    model_phase = model_cfg.buzz_ticks;
                    model_cycle = model_cfg.cycle_ticks;
                end
            end
        end
        else if (model_mode != MODE_IDLE)
        begin
            if (model_cycle != 0)
                model_cycle--;
            if (model_phase != 0)
                model_phase--;
            if (model_cycle == 0)
            begin
                if (model_mode == MODE_BUZZ)
                    buzz_expiries++;
                model_mode = MODE_IDLE;
                model_phase = '0;
            end
            else if (model_phase == 0)
            begin
                if (model_mode == MODE_BUZZ)
                begin
                    model_mode = MODE_WAIT;
                    model_phase = model_cfg.wait_ticks;
                end
                else
                begin
                    model_mode = MODE_BUZZ;
                    model_phase = model_cfg.buzz_ticks;
                end
            end
        end
        r.mode = model_mode;
        r.buzzer_on = (model_mode == MODE_BUZZ);
        return r;
    endfunction

    function automatic stim_row_t sample_row(input int cl, input bit lv,
                                             input int g0, input int g1, input int g2,
                                             input int a0, input int a1, input int a2);
        stim_row_t row;
        row = '{default: '0};
        row.item.cmd = CMD_SAMPLE;
        row.item.centilux = 23'(cl);
        row.item.lvalid = lv;
        row.item.gyro[0] = clamp_axis(g0);
        row.item.gyro[1] = clamp_axis(g1);
        row.item.gyro[2] = clamp_axis(g2);
        row.item.acc[0] = clamp_axis(a0);
        row.item.acc[1] = clamp_axis(a1);
        row.item.acc[2] = clamp_axis(a2);
        return row;
    endfunction

    function automatic stim_row_t tick_row();
        stim_row_t row;
        row = sample_row(0, 1'b0, 0, 0, 0, 0, 0, 0);
        row.item.cmd = CMD_TICK;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_row_t row;
        row = tick_row();
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = CFG_DATA_W'(val);
        return row;
    endfunction

    function automatic stim_row_t expecting(input stim_row_t row, input logic [1:0] m,
                                            input logic s, input logic lh,
                                            input logic gh, input logic ah);
        row.has_exp = 1'b1;
        row.exp_res = {m, m == MODE_BUZZ, s, lh, gh, ah};
        return row;
    endfunction

    function automatic sample_t random_item();
        sample_t it;
        int spread;
        int lux;
        int cl;
        int gth;
        int target;
        int k;
        it.cmd = CMD_SAMPLE;
        if (model_mode == MODE_IDLE)
        begin
            if ($urandom_range(0, 9) == 0)
                it.cmd = CMD_TICK;
        end
        else if ($urandom_range(0, 9) != 0)
        begin
            it.cmd = CMD_TICK;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            it.centilux = 23'($urandom);
            it.lvalid = 1'($urandom);
            for (int i = 0; i < 3; i++)
            begin
                it.gyro[i] = 16'($urandom);
                it.acc[i] = 16'($urandom);
            end
        end
        else
        begin
            it.lvalid = ($urandom_range(0, 7) != 0);
            spread = int'(model_cfg.lux_delta_lim) + 2;
            lux = int'(model_last_lux) + int'($urandom_range(0, 2 * spread)) - spread;
            lux = (lux < 0) ? 0 : (lux > MAX_LUX) ? MAX_LUX : lux;
            cl = lux * 100 + int'($urandom_range(0, 99));
            it.centilux = (cl > 8388607) ? 23'h7FFFFF : 23'(cl);
            gth = int'(model_cfg.gyro_rate_lim);
            for (int i = 0; i < 3; i++)
                it.gyro[i] = clamp_axis(rand_sign() * int'($urandom_range(0, gth)));
            if ($urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(0, 2);
                it.gyro[k] = clamp_axis(rand_sign() * (gth + int'($urandom_range(0, 1))));
            end
            spread = 2 * int'(model_cfg.acc_dev_lim) + 2;
            target = int'(model_cfg.acc_nominal) + int'($urandom_range(0, 2 * spread))
                     - spread;
            if (target < 0)
                target = 0;
            for (int i = 0; i < 3; i++)
                it.acc[i] = clamp_axis(int'($urandom_range(0, 6)) - 3);
            k = $urandom_range(0, 2);
            it.acc[k] = clamp_axis(rand_sign() * target);
        end
        return it;
    endfunction

    task automatic send_item(input sample_t it, input bit has_exp, input result_t typed);
        result_t pred;
        in_valid <= 1'b1;
        cmd <= it.cmd;
        light_centilux <= it.centilux;
        light_valid <= it.lvalid;
        gyro_x <= it.gyro[0];
        gyro_y <= it.gyro[1];
        gyro_z <= it.gyro[2];
        acc_x <= it.acc[0];
        acc_y <= it.acc[1];
        acc_z <= it.acc[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = predict_alarm_result(it);
        pending_results.push_back(has_exp ? typed : pred);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LIGHT_TH:    model_cfg.lux_delta_lim = v[LIGHT_TH_W-1:0];
            REG_GYRO_TH:     model_cfg.gyro_rate_lim = v[GYRO_TH_W-1:0];
            REG_ACC_TH:      model_cfg.acc_dev_lim = v[ACC_W-1:0];
            REG_ACC_NOMINAL: model_cfg.acc_nominal = v[ACC_W-1:0];
            REG_BUZZ_TICKS:  model_cfg.buzz_ticks = v[TICKS_W-1:0];
            REG_WAIT_TICKS:  model_cfg.wait_ticks = v[TICKS_W-1:0];
            REG_CYCLE_TICKS: model_cfg.cycle_ticks = v[TICKS_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin : result_sink
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {mode, buzzer_on, significant, light_hit, gyro_hit, acc_hit};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Unexpected result transaction: ",
                              "mode=%0d buzzer=%0b sig=%0b hits=%b"},
                             got.mode, got.buzzer_on, got.significant, got.hits);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.mode !== want.mode || got.buzzer_on !== want.buzzer_on
                    || got.significant !== want.significant
                    || got.hits.light_hit !== want.hits.light_hit
                    || got.hits.gyro_hit !== want.hits.gyro_hit
                    || got.hits.acc_hit !== want.hits.acc_hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch on result %0d: expected mode=%0d buzzer=%0b ",
                                  "sig=%0b hits=%b, got mode=%0d buzzer=%0b sig=%0b hits=%b"},
                                 results_checked, want.mode, want.buzzer_on, want.significant,
                                 want.hits, got.mode, got.buzzer_on, got.significant,
                                 got.hits);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t directed [$];
        int light_v, gyro_v, acc_th_v, nominal_v, buzz_v, wait_v, cycle_v;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_SAMPLE;
        light_centilux = '0;
        light_valid = 1'b0;
        gyro_x = '0;
        gyro_y = '0;
        gyro_z = '0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;

        model_cfg = '{RST_LIGHT_TH, RST_GYRO_TH, RST_ACC_TH, RST_ACC_NOMINAL,
                      RST_BUZZ_TICKS, RST_WAIT_TICKS, RST_CYCLE_TICKS};
        model_mode = MODE_IDLE;
        model_phase = '0;
        model_cycle = '0;
        model_last_lux = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A tick while idle, a sample just inside the light and gyro reset thresholds
        // at the nominal acceleration, and a full-scale negative gyro axis that starts the alarm.
        directed.push_back(expecting(tick_row(), MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0));
        directed.push_back(expecting(sample_row(29999, 1'b1, 5000, -5000, 0, 100, 0, 0),
                                     MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0));
        directed.push_back(cfg_row(REG_BUZZ_TICKS, 3));
        directed.push_back(cfg_row(REG_WAIT_TICKS, 1));
        directed.push_back(cfg_row(REG_CYCLE_TICKS, 5));
        directed.push_back(expecting(sample_row(0, 1'b0, -32768, 0, 0, 0, 0, 100),
                                     MODE_BUZZ, 1'b1, 1'b0, 1'b1, 1'b0));
        directed.push_back(expecting(sample_row(8388607, 1'b1, 0, 0, 0,
                                                -32768, -32768, -32768),
                                     MODE_BUZZ, 1'b0, 1'b0, 1'b0, 1'b0));
        // The cycle timer runs out in the middle of a buzz phase.
        repeat (6) directed.push_back(tick_row());
        directed.push_back(cfg_row(REG_CYCLE_TICKS, 1));
        directed.push_back(sample_row(8388607, 1'b1, 0, 0, 0, 0, 100, 0));
        directed.push_back(tick_row());
        directed.push_back(sample_row(0, 1'b0, 0, 0, 0, -32768, -32768, -32768));
        directed.push_back(tick_row());
        directed.push_back(cfg_row(REG_LIGHT_TH, 131071));
        directed.push_back(cfg_row(REG_GYRO_TH, 32767));
        directed.push_back(cfg_row(REG_ACC_TH, 1023));
        directed.push_back(cfg_row(REG_ACC_NOMINAL, 1023));
        directed.push_back(sample_row(8388607, 1'b1, 32767, -32767, 32767, 0, 0, 0));
        directed.push_back(sample_row(8388607, 1'b1, 0, 0, -32768, 0, 0, 0));
        directed.push_back(tick_row());
        // Phase counters loaded with zero, then a cycle counter loaded with zero.
        directed.push_back(cfg_row(REG_BUZZ_TICKS, 0));
        directed.push_back(cfg_row(REG_WAIT_TICKS, 0));
        directed.push_back(cfg_row(REG_CYCLE_TICKS, 3));
        directed.push_back(cfg_row(REG_UNUSED, 131071));
        directed.push_back(sample_row(8388607, 1'b1, 0, -32768, 0, 0, 0, 0));
        repeat (3) directed.push_back(tick_row());
        directed.push_back(cfg_row(REG_CYCLE_TICKS, 0));
        directed.push_back(sample_row(8388607, 1'b1, -32768, 0, 0, 0, 0, 0));
        directed.push_back(tick_row());

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                wait_drained();
                write_reg(directed[i].cfg_idx, int'(directed[i].cfg_val));
                settings_used++;
            end
            else
            begin
                send_item(directed[i].item, directed[i].has_exp, directed[i].exp_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
            begin
                light_v = 0;
                gyro_v = 0;
                acc_th_v = 0;
                nominal_v = 0;
                buzz_v = 1;
                wait_v = 1;
                cycle_v = 1;
            end
            else if (p == NUM_PHASES - 1)
            begin
                light_v = 131071;
                gyro_v = 32767;
                acc_th_v = 1023;
                nominal_v = 1023;
                buzz_v = 65535;
                wait_v = 65535;
                cycle_v = 65535;
            end
            else
            begin
                light_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                      : $urandom_range(0, 500);
                gyro_v = $urandom_range(0, 32767);
                acc_th_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 60);
                nominal_v = $urandom_range(0, 1023);
                buzz_v = $urandom_range(1, 5);
                wait_v = $urandom_range(1, 5);
                cycle_v = $urandom_range(1, 25);
            end
            write_reg(REG_LIGHT_TH, light_v);
            write_reg(REG_GYRO_TH, gyro_v);
            write_reg(REG_ACC_TH, acc_th_v);
            write_reg(REG_ACC_NOMINAL, nominal_v);
            write_reg(REG_BUZZ_TICKS, buzz_v);
            write_reg(REG_WAIT_TICKS, wait_v);
            write_reg(REG_CYCLE_TICKS, cycle_v);
            settings_used++;

            src_gaps = (p != 4) && (p != NUM_PHASES - 1);
            sink_stalls = src_gaps;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 10)
                    hold_req = 1'b1;
                if (src_gaps && !hold_req && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d transactions and checked %0d results over %0d register settings.",
                 items_sent, results_checked, settings_used);
        $display("The alarm was triggered %0d times; %0d cycles expired during a buzz phase.",
                 alarm_triggers, buzz_expiries);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: change_triggered_alarm_sequencer.f
hw/rtl/ctas_pkg.sv
hw/rtl/ctas_cfg_regs.sv
hw/rtl/ctas_judge.sv
hw/rtl/ctas_seq.sv
hw/rtl/change_triggered_alarm_sequencer.sv
dv/testbench.sv
